[rtl/adsl_pkg.sv]
// Shared types and constants for the adaptive decimating sample log.
// Used by adsl_store, adsl_ctrl and adaptive_decimating_sample_log.
`timescale 1ns / 1ps

package adsl_pkg;

    localparam int ADC_W      = 10;                     // raw converter reading
    localparam int SAMPLE_W   = 8;                      // reading after truncation
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int REQ_W      = 2;

    // request codes carried in s_tuser; code 3 is unused
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_COMPACT = 4'b0010,
        ST_ADD     = 4'b0100,
        ST_READ    = 4'b1000
    } state_t;

endpackage

[rtl/adsl_store.sv]
// Entry store: one write port, two registered read ports.
// Depends on adsl_pkg for the entry width.
`timescale 1ns / 1ps

module adsl_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [adsl_pkg::SAMPLE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]            raddr_a,
    input  logic [ADDR_W-1:0]            raddr_b,
    output logic [adsl_pkg::SAMPLE_W-1:0] rdata_a,
    output logic [adsl_pkg::SAMPLE_W-1:0] rdata_b
);

    logic [adsl_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/adsl_ctrl.sv]
// Request sequencer: decimation state, group accumulation, compaction sweep
// and read-out against the entry store. Depends on adsl_pkg.
`timescale 1ns / 1ps

module adsl_ctrl #(
    parameter int STORE_DEPTH = 256,
    parameter int MAX_RATIO   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  adsl_pkg::req_t                    req,
    input  logic [adsl_pkg::SAMPLE_W-1:0]     sample,
    input  logic [$clog2(STORE_DEPTH)-1:0]    index,
    output logic                              idle,
    output logic                              done,
    output logic                              res_accepted,
    output logic [$clog2(STORE_DEPTH+1)-1:0]  res_count,
    output logic [$clog2(2*MAX_RATIO)-1:0]    res_ratio,
    output logic [adsl_pkg::SAMPLE_W-1:0]     res_rdata,
    output logic                              res_rvalid,
    // store ports
    output logic                              mem_we,
    output logic [$clog2(STORE_DEPTH)-1:0]    mem_waddr,
    output logic [adsl_pkg::SAMPLE_W-1:0]     mem_wdata,
    output logic [$clog2(STORE_DEPTH)-1:0]    mem_raddr_a,
    output logic [$clog2(STORE_DEPTH)-1:0]    mem_raddr_b,
    input  logic [adsl_pkg::SAMPLE_W-1:0]     mem_rdata_a,
    input  logic [adsl_pkg::SAMPLE_W-1:0]     mem_rdata_b
);

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int RAT_W  = $clog2(2 * MAX_RATIO);
    localparam int SH_W   = $clog2(RAT_W);
    localparam int FILL_W = $clog2(MAX_RATIO);
    localparam int SUM_W  = $clog2(adsl_pkg::SAMPLE_MAX * MAX_RATIO + 1);
    localparam int NPAIR  = STORE_DEPTH / 2;
    localparam int PAIR_W = $clog2(NPAIR);
    localparam int SW     = adsl_pkg::SAMPLE_W;

    adsl_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RAT_W-1:0]   ratio_reg, ratio_next;
    logic [SH_W-1:0]    shift_reg, shift_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SW-1:0]      sample_reg, sample_next;
    logic [PAIR_W-1:0]  pair_reg, pair_next;
    logic               issue_done_reg, issue_done_next;
    logic               pend_reg, pend_next;
    logic [PAIR_W-1:0]  wpair_reg, wpair_next;

    logic               do_add;
    logic [SW-1:0]      add_sample;
    logic [SUM_W-1:0]   sum_new;
    logic [RAT_W-1:0]   fill_inc;
    logic               group_close;
    logic [SW-1:0]      group_avg;
    logic [SW:0]        pair_sum;

    assign idle       = (state_reg == adsl_pkg::ST_IDLE);
    assign add_sample = (state_reg == adsl_pkg::ST_ADD) ? sample_reg : sample;
    assign sum_new    = sum_reg + SUM_W'(add_sample);
    assign fill_inc   = RAT_W'(fill_reg) + RAT_W'(1);
    assign group_close = !(fill_inc < ratio_reg);
    // ratio is a power of two: the truncated average is a shift
    assign group_avg  = SW'(sum_new >> shift_reg);
    assign pair_sum   = {1'b0, mem_rdata_a} + {1'b0, mem_rdata_b};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ratio_next      = ratio_reg;
        shift_next      = shift_reg;
        fill_next       = fill_reg;
        sum_next        = sum_reg;
        sample_next     = sample_reg;
        pair_next       = pair_reg;
        issue_done_next = issue_done_reg;
        pend_next       = pend_reg;
        wpair_next      = wpair_reg;
        do_add          = 1'b0;
        done            = 1'b0;
        res_accepted    = 1'b0;
        res_rdata       = '0;
        res_rvalid      = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_wdata       = group_avg;
        mem_raddr_a     = index;
        mem_raddr_b     = '0;

        unique case (state_reg)
            adsl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req)
                        adsl_pkg::REQ_ADD:
                        begin
                            if (ratio_reg >= RAT_W'(MAX_RATIO))
                            begin
                                done = 1'b1;   // ratio limit: refused
                            end
                            else if (count_reg >= CNT_W'(STORE_DEPTH))
                            begin
                                state_next      = adsl_pkg::ST_COMPACT;
                                sample_next     = sample;
                                pair_next       = '0;
                                issue_done_next = 1'b0;
                                pend_next       = 1'b0;
                            end
                            else
                            begin
                                do_add = 1'b1;
                            end
                        end
                        adsl_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            ratio_next = RAT_W'(1);
                            shift_next = '0;
                            fill_next  = '0;
                            sum_next   = '0;
                            done       = 1'b1;
                        end
                        adsl_pkg::REQ_READ:
                        begin
                            if (CNT_W'(index) < count_reg)
                            begin
                                state_next = adsl_pkg::ST_READ;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end

            adsl_pkg::ST_COMPACT:
            begin
                // issue pair reads, write the average in the cycle after each read
                mem_raddr_a = IDX_W'({pair_reg, 1'b0});
                mem_raddr_b = IDX_W'({pair_reg, 1'b1});
                pend_next   = !issue_done_reg;
                wpair_next  = pair_reg;
                if (!issue_done_reg)
                begin
                    pair_next = pair_reg + PAIR_W'(1);
                    if (pair_reg == PAIR_W'(NPAIR - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(wpair_reg);
                    mem_wdata = pair_sum[SW:1];
                    if (wpair_reg == PAIR_W'(NPAIR - 1))
                    begin
                        state_next = adsl_pkg::ST_ADD;
                        count_next = CNT_W'(NPAIR);
                        ratio_next = ratio_reg << 1;
                        shift_next = shift_reg + SH_W'(1);
                        pend_next  = 1'b0;
                    end
                end
            end

            adsl_pkg::ST_ADD:
            begin
                do_add = 1'b1;
            end

            adsl_pkg::ST_READ:
            begin
                done       = 1'b1;
                res_rvalid = 1'b1;
                res_rdata  = mem_rdata_a;
                state_next = adsl_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = adsl_pkg::ST_IDLE;
            end
        endcase

        if (do_add)
        begin
            done         = 1'b1;
            res_accepted = 1'b1;
            state_next   = adsl_pkg::ST_IDLE;
            if (group_close)
            begin
                mem_we     = 1'b1;
                mem_waddr  = count_reg[IDX_W-1:0];
                mem_wdata  = group_avg;
                count_next = count_reg + CNT_W'(1);
                fill_next  = '0;
                sum_next   = '0;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
                sum_next  = sum_new;
            end
        end
    end

    assign res_count = count_next;
    assign res_ratio = ratio_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= adsl_pkg::ST_IDLE;
            count_reg      <= '0;
            ratio_reg      <= RAT_W'(1);
            shift_reg      <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            pair_reg       <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            wpair_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ratio_reg      <= ratio_next;
            shift_reg      <= shift_next;
            fill_reg       <= fill_next;
            sum_reg        <= sum_next;
            pair_reg       <= pair_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            wpair_reg      <= wpair_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

endmodule

[rtl/adaptive_decimating_sample_log.sv]
// Top level of the adaptive decimating sample log: stream ports, request
// holding register, result register. Depends on adsl_pkg, adsl_store, adsl_ctrl.
`timescale 1ns / 1ps

// Channel  Dir  Signals                          Payload
// s_*      in   s_tvalid s_tready s_tuser s_tdata req_type; adc_reading, read_index
// m_*      out  m_tvalid m_tready m_tdata         accepted .. read_valid
//
// Add, clear and refused or out-of-range reads: the result is decided in the
// idle state and registered; an in-range read first passes the READ state.
// An add that finds the store full first runs a compaction sweep, one pair
// averaged per cycle through the store's single write port; the sample is
// then added in the ADD state and its result registered.
// Reset (rst_n, async, active low) clears count, ratio and the open group;
// store contents stay undefined and are only read below the valid count.
// One transaction is in work at a time; a second one is held in the input
// register while a result waits on m_tready.

module adaptive_decimating_sample_log #(
    parameter int STORE_DEPTH = 256,
    parameter int MAX_RATIO   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [adsl_pkg::REQ_W-1:0] s_tuser,   // [1:0] req_type
    // from bit 0: adc_reading (10), read_index ($clog2(STORE_DEPTH)), zero pad
    input  logic [((adsl_pkg::ADC_W + $clog2(STORE_DEPTH) + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // from bit 0: accepted (1), stored_count, decimation_ratio,
    // read_data (8), read_valid (1), zero pad
    output logic [((adsl_pkg::SAMPLE_W + $clog2(STORE_DEPTH + 1)
                    + $clog2(2 * MAX_RATIO) + 9) / 8) * 8 - 1:0] m_tdata
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int RAT_W = $clog2(2 * MAX_RATIO);
    localparam int SW    = adsl_pkg::SAMPLE_W;
    localparam int PAY_W = 1 + CNT_W + RAT_W + SW + 1;
    localparam int M_W   = ((PAY_W + 7) / 8) * 8;

    // held request
    logic               req_valid_reg, req_valid_next;
    adsl_pkg::req_t     req_type_reg;
    logic [SW-1:0]      sample_reg;
    logic [IDX_W-1:0]   index_reg;

    // result register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_W-1:0]     out_data_reg;

    logic               start;
    logic               s_fire;
    logic               ctrl_idle;
    logic               done;
    logic               res_accepted;
    logic [CNT_W-1:0]   res_count;
    logic [RAT_W-1:0]   res_ratio;
    logic [SW-1:0]      res_rdata;
    logic               res_rvalid;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [SW-1:0]      mem_wdata;
    logic [IDX_W-1:0]   mem_raddr_a;
    logic [IDX_W-1:0]   mem_raddr_b;
    logic [SW-1:0]      mem_rdata_a;
    logic [SW-1:0]      mem_rdata_b;

    // hand the held request to the sequencer once the result slot is free
    // (or drains this cycle), so a finished result never has to wait inside
    assign start    = req_valid_reg && ctrl_idle && (!m_tvalid_reg || m_tready);
    assign s_tready = !req_valid_reg || start;
    assign s_fire   = s_tvalid && s_tready;

    assign req_valid_next = s_fire || (req_valid_reg && !start);
    assign m_tvalid_next  = done || (m_tvalid_reg && !m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            req_type_reg <= adsl_pkg::req_t'(s_tuser);
            // reading cut to 8 bits by dropping the two low bits
            sample_reg   <= s_tdata[adsl_pkg::ADC_W-1 -: SW];
            index_reg    <= s_tdata[adsl_pkg::ADC_W +: IDX_W];
        end
        if (done)
        begin
            out_data_reg <= M_W'({res_rvalid, res_rdata, res_ratio, res_count,
                                  res_accepted});
        end
    end

    adsl_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    adsl_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_RATIO   (MAX_RATIO)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req_type_reg),
        .sample       (sample_reg),
        .index        (index_reg),
        .idle         (ctrl_idle),
        .done         (done),
        .res_accepted (res_accepted),
        .res_count    (res_count),
        .res_ratio    (res_ratio),
        .res_rdata    (res_rdata),
        .res_rvalid   (res_rvalid),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr_a  (mem_raddr_a),
        .mem_raddr_b  (mem_raddr_b),
        .mem_rdata_a  (mem_rdata_a),
        .mem_rdata_b  (mem_rdata_b)
    );

endmodule

[tb/adsl_checker.sv]
// Result checker for the adaptive decimating sample log: watches both stream
// channels, predicts each result and compares it. Depends on adsl_pkg.
`timescale 1ns / 1ps

module adsl_checker #(
    parameter int IN_W  = 24,
    parameter int OUT_W = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [adsl_pkg::REQ_W-1:0]    s_tuser,
    input  logic [IN_W-1:0]               s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [OUT_W-1:0]              m_tdata,
    output int                            fail_count,
    output int                            pending
);

    localparam int LOG_DEPTH   = 256;
    localparam int RATIO_LIMIT = 16;
    localparam int REQ_W       = adsl_pkg::REQ_W;
    localparam int ADC_W       = adsl_pkg::ADC_W;

    // first member sits in the top bits, so accepted lands in bit 0
    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_data;
        logic [4:0] ratio;
        logic [8:0] count;
        logic       accepted;
    } log_status_t;

    logic [7:0]  log_mem [LOG_DEPTH];
    logic [8:0]  log_count;
    logic [4:0]  log_ratio;
    logic [3:0]  grp_fill;
    logic [11:0] grp_sum;

    log_status_t expected_status [$];
    log_status_t want_st;
    log_status_t seen_st;

    function automatic log_status_t apply_request(logic [REQ_W-1:0] req,
                                                  logic [ADC_W-1:0] reading,
                                                  logic [7:0] index);
        log_status_t st;
        logic [8:0]  pair_sum;
        st = '0;
        case (req)
            adsl_pkg::REQ_ADD:
            begin
                if (log_ratio < RATIO_LIMIT)
                begin
                    // full store: fold pairs into the lower half, ratio doubles
                    if (log_count == LOG_DEPTH)
                    begin
                        for (int i = 0; i < LOG_DEPTH / 2; i++)
                        begin
                            pair_sum   = log_mem[2 * i] + log_mem[2 * i + 1];
                            log_mem[i] = pair_sum[8:1];
                        end
                        log_count = 9'(LOG_DEPTH / 2);
                        log_ratio = log_ratio << 1;
                    end
                    grp_sum = grp_sum + reading[ADC_W-1:2];
                    if (grp_fill + 1 < log_ratio)
                        grp_fill = grp_fill + 4'd1;
                    else
                    begin
                        log_mem[log_count[7:0]] = 8'(grp_sum / log_ratio);
                        log_count = log_count + 9'd1;
                        grp_fill  = '0;
                        grp_sum   = '0;
                    end
                    st.accepted = 1'b1;
                end
            end
            adsl_pkg::REQ_CLEAR:
            begin
                log_count = '0;
                log_ratio = 5'd1;
                grp_fill  = '0;
                grp_sum   = '0;
            end
            adsl_pkg::REQ_READ:
            begin
                if (index < log_count)
                begin
                    st.read_data  = log_mem[index];
                    st.read_valid = 1'b1;
                end
            end
            default:
                ;
        endcase
        st.count = log_count;
        st.ratio = log_ratio;
        return st;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_count = '0;
            log_ratio = 5'd1;
            grp_fill  = '0;
            grp_sum   = '0;
            expected_status.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want_st = expected_status.pop_front();
                    seen_st = m_tdata[23:0];
                    check_field("accepted", want_st.accepted, seen_st.accepted);
                    check_field("stored_count", want_st.count, seen_st.count);
                    check_field("decimation_ratio", want_st.ratio, seen_st.ratio);
                    check_field("read_data", want_st.read_data, seen_st.read_data);
                    check_field("read_valid", want_st.read_valid, seen_st.read_valid);
                    check_field("tdata pad", 0, m_tdata[OUT_W-1:24]);
                end
            end
            if (s_tvalid && s_tready)
                expected_status.push_back(apply_request(s_tuser, s_tdata[9:0],
                                                        s_tdata[17:10]));
            pending = expected_status.size();
        end
    end

endmodule

[tb/adaptive_decimating_sample_log_tb.sv]
// Testbench top for the adaptive decimating sample log: clock, reset, request
// stimulus and result backpressure. Depends on adsl_pkg, adsl_checker and the RTL.
`timescale 1ns / 1ps

module adaptive_decimating_sample_log_tb;

    localparam int STORE_DEPTH = 256;
    localparam int MAX_RATIO   = 16;
    localparam int REQ_W       = adsl_pkg::REQ_W;
    localparam int ADC_W       = adsl_pkg::ADC_W;
    localparam int IN_W        = 24;     // adc_reading (10), read_index (8), pad
    localparam int OUT_W       = 32;     // status fields (24), pad

    // request code 3 has no meaning; the block must leave its state alone
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Keep a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT  = 400000;
    // Longest single transaction is an add that runs a compaction sweep.
    localparam int DRAIN_CYCLES = STORE_DEPTH / 2 + 8;
    localparam int HOLD_CYCLES  = 300;
    // Adds enough to fill the log from empty and run one compaction.
    localparam int DEEP_ADDS    = 280;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [REQ_W-1:0]   s_tuser  = '0;     // [1:0] req_type
    logic [IN_W-1:0]    s_tdata  = '0;     // [9:0] adc_reading, [17:10] read_index
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;           // accepted, count, ratio, data, valid

    int fail_count;
    int pending;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;
    int cycle_cnt     = 0;

    always #6 clk = ~clk;

    adaptive_decimating_sample_log #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_RATIO   (MAX_RATIO)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    adsl_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side. A single long hold-off, once requested, starves the output
    // so the block backs up and drops s_tready; otherwise random stalls.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Offer one request; called and returns at a falling edge. Valid stays
    // high across back-to-back transactions and only drops for idle cycles.
    task automatic send_req(logic [REQ_W-1:0] req, logic [ADC_W-1:0] reading,
                            logic [7:0] index);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tuser  = req;
        s_tdata  = IN_W'({index, reading});
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Readings lean on the extremes now and then; indexes lean low so reads
    // usually land inside a short log.
    function automatic logic [ADC_W-1:0] pick_reading();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return ADC_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(0, 31));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mixed traffic, mostly adds so the log keeps growing between clears.
    task automatic send_mixed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            send_req(adsl_pkg::REQ_ADD, pick_reading(), pick_index());
        else if (roll < 93)
            send_req(adsl_pkg::REQ_READ, pick_reading(), pick_index());
        else if (roll < 97)
            send_req(adsl_pkg::REQ_CLEAR, pick_reading(), pick_index());
        else
            send_req(REQ_UNUSED, pick_reading(), pick_index());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty log, unused code, truncation of the low reading
        // bits, reads at and past the count, clear and restart.
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd0);
        send_req(REQ_UNUSED, 10'h3FF, 8'hFF);
        send_req(adsl_pkg::REQ_ADD, 10'd0, 8'd0);
        send_req(adsl_pkg::REQ_ADD, 10'h3FF, 8'hFF);
        send_req(adsl_pkg::REQ_ADD, 10'd3, 8'd0);
        send_req(adsl_pkg::REQ_ADD, 10'd4, 8'd0);
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd0);
        send_req(adsl_pkg::REQ_READ, 10'h3FF, 8'd1);
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd3);
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd4);
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'hFF);
        send_req(adsl_pkg::REQ_ADD, 10'h3FF, 8'hFF);
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd4);
        send_req(adsl_pkg::REQ_CLEAR, 10'h3FF, 8'hFF);
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd0);
        send_req(adsl_pkg::REQ_ADD, 10'h200, 8'd0);
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd0);
        send_req(adsl_pkg::REQ_CLEAR, 10'd0, 8'd0);
        send_req(adsl_pkg::REQ_CLEAR, 10'd0, 8'd0);
        send_req(REQ_UNUSED, 10'd0, 8'd0);

        // Random traffic across the idle/stall phases. The first phase also
        // carries the long output hold-off while the input keeps pushing.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                    hold_req      = 1'b1;
                end
                1:
                begin
                    src_idle_pct  = 87;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 87;
                end
                default:
                begin
                    src_idle_pct  = 15;
                    snk_stall_pct = 15;
                end
            endcase
            repeat (60) send_mixed();
        end

        // Long fill from a cleared log: fills the store, compacts it once and
        // keeps adding at the doubled ratio, with reads sprinkled in.
        send_req(adsl_pkg::REQ_CLEAR, pick_reading(), pick_index());
        repeat (DEEP_ADDS)
        begin
            if ($urandom_range(0, 9) == 0)
                send_req(adsl_pkg::REQ_READ, pick_reading(), 8'($urandom_range(0, 255)));
            send_req(adsl_pkg::REQ_ADD, pick_reading(), pick_index());
        end
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd127);
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd128);
        send_req(REQ_UNUSED, 10'h3FF, 8'hFF);
        send_req(adsl_pkg::REQ_CLEAR, 10'd0, 8'd0);
        repeat (4) send_req(adsl_pkg::REQ_ADD, pick_reading(), 8'd0);
        send_req(adsl_pkg::REQ_READ, 10'd0, 8'd3);
        s_tvalid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
rtl/adsl_pkg.sv
rtl/adsl_store.sv
rtl/adsl_ctrl.sv
rtl/adaptive_decimating_sample_log.sv
tb/adsl_checker.sv
tb/adaptive_decimating_sample_log_tb.sv
